/* design/hpq_pkg.sv */
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the binary max-heap priority queue: request
// codes, sequencer states, the data word and the comparator decision bundle.
// ----------------------------------------------------------------------------
package hpq_pkg;

   // data word held in the heap
   localparam int DATA_W = 32;
   typedef logic signed [DATA_W-1:0] hpq_data_type;

   // value reported for an empty heap or a request that removed nothing
   localparam hpq_data_type EMPTY_VALUE = -32'sd1;

   // request codes
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } hpq_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST_WAIT,
      ST_DOWN_READ,
      ST_DOWN_CMP,
      ST_UP_READ,
      ST_UP_CMP
   } hpq_state_type;

   // comparator decisions for one tree level
   typedef struct packed {
      logic take_right;
      logic sink;
      logic rise;
   } hpq_pick_type;

endpackage

/* design/binary_max_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_core
// Binary max-heap priority queue kept in one on-chip memory with a registered
// read, walked one tree level at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at a rising edge with start high and busy low:
//   req_op selects push (req_value is inserted) or pop (the maximum leaves).
//   busy stays high until the request is finished; each request gives exactly
//   one response, shown for one cycle with rsp_valid high. The receiver
//   cannot stall, so rsp_* must be captured in that cycle.
//   Every response carries the popped value (-1 if none), the new maximum
//   (-1 when empty), the entry count and a flag for a push refused when full.
// Timing
//   Each tree level takes a read state, which reads the parent or both
//   children from the memory, and a compare state, which compares and
//   writes back. A pop first fetches the last entry to refill the root, then
//   sinks it level by level; a push climbs level by level from the new leaf.
//   A pop on an empty or a push on a full heap finishes without any tree
//   level. The response shows in the first cycle with busy low, and a new
//   request may be taken at the edge that ends it.
// Reset
//   reset empties the heap at once; the memory itself is not cleared, only
//   entries below the count are ever used.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_core #(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     start,
   output logic                                     busy,
   input  hpq_pkg::hpq_op_type                      req_op,
   input  hpq_pkg::hpq_data_type                    req_value,
   // response channel
   output logic                                     rsp_valid,
   output hpq_pkg::hpq_data_type                    rsp_popped_value,
   output logic                                     rsp_popped_valid,
   output hpq_pkg::hpq_data_type                    rsp_top_value,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]          rsp_entry_count,
   output logic                                     rsp_push_dropped
);
   import hpq_pkg::*;

   localparam int AW  = $clog2(HEAP_DEPTH);
   localparam int CW  = $clog2(HEAP_DEPTH + 1);
   localparam int CIW = AW + 1;

   // heap storage, one write and two registered reads per cycle
   hpq_data_type heap_mem [HEAP_DEPTH];
   hpq_data_type mem_rd_a_ff;
   hpq_data_type mem_rd_b_ff;
   logic         mem_we;
   logic [AW-1:0] mem_waddr;
   hpq_data_type mem_wdata;
   logic [AW-1:0] mem_raddr_a;
   logic [AW-1:0] mem_raddr_b;

   // sequencer and datapath registers
   hpq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   hpq_data_type  item_ff, item_in;
   hpq_data_type  root_ff;
   logic          done;

   // response registers
   logic          rsp_valid_ff;
   hpq_data_type  popped_value_ff, popped_value_in;
   logic          popped_valid_ff, popped_valid_in;
   logic          push_dropped_ff, push_dropped_in;

   // index arithmetic
   logic [CW-1:0]  count_dec;
   logic [CIW-1:0] left_idx;
   logic [CIW-1:0] right_idx;
   logic [CIW-1:0] count_ext;
   logic [AW-1:0]  pos_dec;
   logic [AW-1:0]  parent_idx;
   logic           count_full;
   hpq_pick_type   pick;

   assign count_dec  = count_ff - CW'(1);
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + CIW'(1);
   assign count_ext  = CIW'(count_ff);
   assign pos_dec    = pos_ff - AW'(1);
   assign parent_idx = pos_dec >> 1;
   assign count_full = (count_ff == CW'(HEAP_DEPTH));

   // level comparator
   hpq_cmp u_cmp (
      .item      (item_ff),
      .left_val  (mem_rd_a_ff),
      .right_val (mem_rd_b_ff),
      .has_right (right_idx < count_ext),
      .pick      (pick)
   );

   // memory write and reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_a_ff <= heap_mem[mem_raddr_a];
      mem_rd_b_ff <= heap_mem[mem_raddr_b];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_PUSH) begin
                  state_in = count_full ? ST_IDLE : ST_UP_READ;
               end else begin
                  state_in = (count_ff == '0) ? ST_IDLE : ST_LAST_WAIT;
               end
            end
         end
         ST_LAST_WAIT: begin
            state_in = (count_ff == '0) ? ST_IDLE : ST_DOWN_READ;
         end
         ST_DOWN_READ: begin
            state_in = (left_idx >= count_ext) ? ST_IDLE : ST_DOWN_CMP;
         end
         ST_DOWN_CMP: begin
            state_in = pick.sink ? ST_DOWN_READ : ST_IDLE;
         end
         ST_UP_READ: begin
            state_in = (pos_ff == '0) ? ST_IDLE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = pick.rise ? ST_UP_READ : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath control and memory accesses
   always_comb begin
      mem_we          = 1'b0;
      mem_waddr       = pos_ff;
      mem_wdata       = item_ff;
      mem_raddr_a     = left_idx[AW-1:0];
      mem_raddr_b     = right_idx[AW-1:0];
      count_in        = count_ff;
      pos_in          = pos_ff;
      item_in         = item_ff;
      done            = 1'b0;
      popped_value_in = popped_value_ff;
      popped_valid_in = popped_valid_ff;
      push_dropped_in = push_dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in         = req_value;
               popped_value_in = EMPTY_VALUE;
               popped_valid_in = 1'b0;
               push_dropped_in = 1'b0;
               if (req_op == OP_PUSH) begin
                  if (count_full) begin
                     push_dropped_in = 1'b1;
                     done            = 1'b1;
                  end else begin
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  done = 1'b1;
               end else begin
                  // fetch the last entry, it refills the root
                  count_in        = count_dec;
                  mem_raddr_a     = count_dec[AW-1:0];
                  popped_value_in = root_ff;
                  popped_valid_in = 1'b1;
               end
            end
         end
         ST_LAST_WAIT: begin
            item_in = mem_rd_a_ff;
            pos_in  = '0;
            done    = (count_ff == '0);
         end
         ST_DOWN_READ: begin
            // leaf reached: park the moving entry here
            if (left_idx >= count_ext) begin
               mem_we = 1'b1;
               done   = 1'b1;
            end
         end
         ST_DOWN_CMP: begin
            if (pick.sink) begin
               mem_we    = 1'b1;
               mem_wdata = pick.take_right ? mem_rd_b_ff : mem_rd_a_ff;
               pos_in    = pick.take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
            end else begin
               mem_we = 1'b1;
               done   = 1'b1;
            end
         end
         ST_UP_READ: begin
            mem_raddr_a = parent_idx;
            if (pos_ff == '0) begin
               mem_we = 1'b1;
               done   = 1'b1;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (pick.rise) begin
               mem_wdata = mem_rd_a_ff;
               pos_in    = parent_idx;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= done;
      end
   end

   // payload registers; root copy follows every write to the root slot
   always_ff @(posedge clock) begin
      pos_ff          <= pos_in;
      item_ff         <= item_in;
      popped_value_ff <= popped_value_in;
      popped_valid_ff <= popped_valid_in;
      push_dropped_ff <= push_dropped_in;
      if (mem_we && (mem_waddr == '0)) begin
         root_ff <= mem_wdata;
      end
   end

   // response ports
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_value_ff;
   assign rsp_popped_valid = popped_valid_ff;
   assign rsp_push_dropped = push_dropped_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_top_value    = (count_ff != '0) ? root_ff : EMPTY_VALUE;

endmodule

/* design/hpq_cmp.sv */
// ----------------------------------------------------------------------------
// hpq_cmp
// Level comparator: picks the larger child for a sift-down step, decides
// whether the moving entry sinks below it, and whether a pushed entry rises
// above its parent.
// ----------------------------------------------------------------------------
module hpq_cmp (
   input  hpq_pkg::hpq_data_type item,
   input  hpq_pkg::hpq_data_type left_val,
   input  hpq_pkg::hpq_data_type right_val,
   input  logic                  has_right,
   output hpq_pkg::hpq_pick_type pick
);
   import hpq_pkg::*;

   hpq_data_type child_val;

   // larger child, left wins ties; parent value arrives on the left input
   always_comb begin
      pick.take_right = has_right && (left_val < right_val);
      child_val       = pick.take_right ? right_val : left_val;
      pick.sink       = child_val > item;
      pick.rise       = item > left_val;
   end

endmodule
